// ===== rtl/core/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// Metronome subdivision scheduler package
// Shared widths, register map, click codes and the classifier result type.
// ----------------------------------------------------------------------------
package mss_pkg;

  // Beat grid.
  localparam int unsigned SUBS_PER_BEAT         = 60;
  localparam int unsigned MAX_BEATS_PER_MEASURE = 32;
  localparam int unsigned MAX_COUNT_IN_BEATS    = 16;
  localparam int unsigned DEFAULT_BEATS         = 4;

  // Field widths.
  localparam int unsigned SPACING_W  = 30;
  localparam int unsigned BEATS_W    = 6;
  localparam int unsigned NOTE_W     = 6;
  localparam int unsigned MASK_W     = 32;
  localparam int unsigned CI_LEN_W   = 5;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned SUB_W      = 6;
  localparam int unsigned SP_W       = 11;
  localparam int unsigned CIS_W      = 10;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned ACCENT_W   = 2;
  localparam int unsigned BEAT_NUM_W = 5;

  // Multiply-and-round unit: Q14.16 spacing times an integer subtick count.
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned MUL_A_W    = SP_W;
  localparam int unsigned MUL_P_W    = MUL_A_W + SPACING_W;
  localparam int unsigned MUL_RES_W  = MUL_P_W + 1 - FRAC_W;

  // Configuration port.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_SPACING    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CI_SPACING = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BEATS      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_NOTE       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GROUP_MASK = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CI_LENGTH  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_START_DLY  = 3'd6;

  // Register reset values.
  localparam logic [SPACING_W-1:0] RST_SPACING    = 30'd26214400;
  localparam logic [SPACING_W-1:0] RST_CI_SPACING = 30'd26214400;
  localparam logic [BEATS_W-1:0]   RST_BEATS      = 6'd4;
  localparam logic [NOTE_W-1:0]    RST_NOTE       = 6'd4;
  localparam logic [MASK_W-1:0]    RST_GROUP_MASK = 32'd0;
  localparam logic [CI_LEN_W-1:0]  RST_CI_LENGTH  = 5'd0;
  localparam logic [DELAY_W-1:0]   RST_START_DLY  = 16'd12000;
  // With a zero-length count-in the anchor is just the start delay.
  localparam logic [SAMPLE_W-1:0]  RST_ANCHOR     = SAMPLE_W'(RST_START_DLY);

  // Click kinds.
  localparam logic [KIND_W-1:0] KIND_NONE      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BEAT      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EIGHTH    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SIXTEENTH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRIPLET   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_QUINT     = 3'd5;

  // Accent levels.
  localparam logic [ACCENT_W-1:0] ACC_NONE = 2'd0;
  localparam logic [ACCENT_W-1:0] ACC_FULL = 2'd1;
  localparam logic [ACCENT_W-1:0] ACC_HALF = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ACCENT_W-1:0] accent;
  } click_t;

endpackage

// ===== rtl/core/mss_mul_round.sv =====
// ----------------------------------------------------------------------------
// Shared multiply-and-round unit
// Multiplies a subtick count by a Q14.16 spacing and rounds half up to whole
// samples. The result is registered.
// ----------------------------------------------------------------------------
module mss_mul_round import mss_pkg::*; (
  input  logic                 clk_i,
  input  logic [MUL_A_W-1:0]   op_a_i,
  input  logic [SPACING_W-1:0] op_b_i,
  output logic [MUL_RES_W-1:0] res_o
);

  logic [MUL_P_W-1:0]   prod;
  logic [MUL_P_W:0]     rounded;
  logic [MUL_RES_W-1:0] res_q;

  assign prod    = MUL_P_W'(op_a_i) * MUL_P_W'(op_b_i);
  assign rounded = {1'b0, prod} + ((MUL_P_W + 1)'(1) << (FRAC_W - 1));

  always_ff @(posedge clk_i) begin
    res_q <= rounded[FRAC_W +: MUL_RES_W];
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/mss_classify.sv =====
// ----------------------------------------------------------------------------
// Click classifier
// Decides the click kind and accent of a measure subtick from its place in
// the beat, the beat index, the note value and the group mask.
// ----------------------------------------------------------------------------
module mss_classify import mss_pkg::*; (
  input  logic [SUB_W-1:0]   sub_i,
  input  logic [BEATS_W-1:0] beat_i,
  input  logic [NOTE_W-1:0]  note_i,
  input  logic [MASK_W-1:0]  mask_i,
  output click_t             click_o
);

  // Enough multiples to cover the shortest valid step (3 subticks).
  localparam int unsigned MULT_N = 20;
  localparam int unsigned NV60_W = NOTE_W + SUB_W;
  localparam int unsigned PROD_W = 11;

  logic [NOTE_W-1:0] nv;
  logic [NV60_W-1:0] nv60;
  logic [NV60_W-4:0] eighth;
  logic [NV60_W-5:0] sixteenth;
  logic              eighth_ok;
  logic              sixteenth_ok;
  logic              eighth_hit;
  logic              sixteenth_hit;

  assign nv        = (note_i == '0) ? NOTE_W'(DEFAULT_BEATS) : note_i;
  assign nv60      = NV60_W'(nv) * NV60_W'(SUBS_PER_BEAT);
  assign eighth    = nv60[NV60_W-1:3];
  assign sixteenth = nv60[NV60_W-1:4];

  assign eighth_ok    = (eighth != '0) && (eighth < (NV60_W-3)'(SUBS_PER_BEAT));
  assign sixteenth_ok = (sixteenth != '0) &&
                        (sixteenth < (NV60_W-4)'(SUBS_PER_BEAT));

  // The subtick is a multiple of the step when some small multiple of the
  // step equals it; the multiples are checked side by side.
  always_comb begin
    eighth_hit    = 1'b0;
    sixteenth_hit = 1'b0;
    for (int q = 1; q <= MULT_N; q++) begin
      if (PROD_W'(eighth[SUB_W-1:0]) * PROD_W'(q) == PROD_W'(sub_i)) begin
        eighth_hit = 1'b1;
      end
      if (PROD_W'(sixteenth[SUB_W-1:0]) * PROD_W'(q) == PROD_W'(sub_i)) begin
        sixteenth_hit = 1'b1;
      end
    end
  end

  always_comb begin
    click_o.kind   = KIND_NONE;
    click_o.accent = ACC_NONE;
    if (sub_i == '0) begin
      click_o.kind = KIND_BEAT;
      if (beat_i == '0) begin
        click_o.accent = ACC_FULL;
      end else if (beat_i < BEATS_W'(MASK_W) && mask_i[beat_i[4:0]]) begin
        click_o.accent = ACC_HALF;
      end
    end else if (eighth_ok && eighth_hit) begin
      click_o.kind = KIND_EIGHTH;
    end else if (sixteenth_ok && sixteenth_hit) begin
      click_o.kind = KIND_SIXTEENTH;
    end else if (sub_i == 6'd20 || sub_i == 6'd40) begin
      click_o.kind = KIND_TRIPLET;
    end else if (sub_i == 6'd12 || sub_i == 6'd24 || sub_i == 6'd36 || sub_i == 6'd48) begin
      click_o.kind = KIND_QUINT;
    end
  end

endmodule

// ===== rtl/core/metronome_subdivision_scheduler.sv =====
// ----------------------------------------------------------------------------
// Metronome subdivision scheduler
// Walks a count-in and a repeating measure on a grid of 60 subticks per beat
// and reports, for each audio sample, which click starts at that sample.
// ----------------------------------------------------------------------------
// One input item stands for one audio sample; its restart bit starts the walk
// over with that item as sample zero. Every item yields exactly one result
// item giving the click kind, accent, beat number and a count-in flag. Items
// are worked on one at a time by a small sequencer that runs all position
// arithmetic through one shared multiply-and-round unit with a registered
// output: once for the count-in position, once for the measure length and
// once for the measure position, plus once more for the count-in length on a
// restart. The input side is ready only while the sequencer is idle. A
// finished result sits in an output register, so the next item is accepted
// and worked on while the previous result waits to be taken; the sequencer
// holds only if a result is finished before the previous one has left.
// Configuration registers are written through the APB port at byte address
// 4*index and read back the same way. Spacing, beat count, note value and
// group mask take effect on the next sample; start delay and count-in length
// act on the count-in clicks from the next sample but fix the start of the
// first measure only at the next restart.
// ----------------------------------------------------------------------------
module metronome_subdivision_scheduler import mss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input items.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,   // [0] restart, [7:1] zero
  // Result items.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [15:0]           m_axis_tdata_o,   // [2:0] click_kind,
                                                  // [4:3] accent_level,
                                                  // [9:5] beat_number,
                                                  // [15:10] zero
  output logic                  m_axis_tuser_o,   // [0] in_count_in
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Sequencer states.
  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE      = 4'd0;
  localparam logic [ST_W-1:0] ST_RST_MUL   = 4'd1;
  localparam logic [ST_W-1:0] ST_RST_ADD   = 4'd2;
  localparam logic [ST_W-1:0] ST_CI_MUL    = 4'd3;
  localparam logic [ST_W-1:0] ST_CI_EVAL   = 4'd4;
  localparam logic [ST_W-1:0] ST_SPAN_MUL  = 4'd5;
  localparam logic [ST_W-1:0] ST_SPAN_EVAL = 4'd6;
  localparam logic [ST_W-1:0] ST_POS_MUL   = 4'd7;
  localparam logic [ST_W-1:0] ST_POS_EVAL  = 4'd8;
  localparam logic [ST_W-1:0] ST_DONE      = 4'd9;

  logic [ST_W-1:0] state_q, state_d;

  // Configuration registers.
  logic [SPACING_W-1:0] spacing_q, ci_spacing_q;
  logic [BEATS_W-1:0]   beats_q;
  logic [NOTE_W-1:0]    note_q;
  logic [MASK_W-1:0]    mask_q;
  logic [CI_LEN_W-1:0]  ci_len_q;
  logic [DELAY_W-1:0]   delay_q;

  // Walk state. Both subtick counters are kept as a flat count and as
  // beat/subtick-in-beat pairs, all stepped together.
  logic [SAMPLE_W-1:0]   sample_q, sample_d;
  logic [SAMPLE_W-1:0]   anchor_q, anchor_d;
  logic [SP_W-1:0]       sp_q, sp_d;
  logic [SUB_W-1:0]      sp_sub_q, sp_sub_d;
  logic [BEATS_W-1:0]    sp_beat_q, sp_beat_d;
  logic [CIS_W-1:0]      cis_q, cis_d;
  logic [SUB_W-1:0]      cis_sub_q, cis_sub_d;
  logic [CI_LEN_W-1:0]   cis_beat_q, cis_beat_d;
  logic [MUL_RES_W-1:0]  span_q, span_d;

  // Result under construction.
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic [ACCENT_W-1:0]   accent_q, accent_d;
  logic [BEAT_NUM_W-1:0] beat_q, beat_d;
  logic                  counting_q, counting_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [KIND_W-1:0]     out_kind_q;
  logic [ACCENT_W-1:0]   out_accent_q;
  logic [BEAT_NUM_W-1:0] out_beat_q;
  logic                  out_ci_q;
  logic                  out_load;
  logic                  out_free;

  // Shared unit operands and result.
  logic [MUL_A_W-1:0]    mul_a;
  logic [SPACING_W-1:0]  mul_b;
  logic [MUL_RES_W-1:0]  mul_r;

  // Derived values.
  logic [CI_LEN_W-1:0]   len_c;
  logic [CIS_W-1:0]      ci_total;
  logic [BEATS_W-1:0]    beats_c;
  logic [SP_W-1:0]       subs;
  logic [SAMPLE_W-1:0]   ci_pos, ci_diff;
  logic [SAMPLE_W-1:0]   m_pos, m_diff;
  logic                  in_accept;
  logic                  cfg_write;
  logic [REG_IDX_W-1:0]  reg_idx;
  click_t                cls;

  // --------------------------------------------------------------------------
  // Configuration port. Only the word index matters; byte lanes are ignored.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q    <= RST_SPACING;
      ci_spacing_q <= RST_CI_SPACING;
      beats_q      <= RST_BEATS;
      note_q       <= RST_NOTE;
      mask_q       <= RST_GROUP_MASK;
      ci_len_q     <= RST_CI_LENGTH;
      delay_q      <= RST_START_DLY;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_SPACING:    spacing_q    <= pwdata[SPACING_W-1:0];
        REG_CI_SPACING: ci_spacing_q <= pwdata[SPACING_W-1:0];
        REG_BEATS:      beats_q      <= pwdata[BEATS_W-1:0];
        REG_NOTE:       note_q       <= pwdata[NOTE_W-1:0];
        REG_GROUP_MASK: mask_q       <= pwdata[MASK_W-1:0];
        REG_CI_LENGTH:  ci_len_q     <= pwdata[CI_LEN_W-1:0];
        REG_START_DLY:  delay_q      <= pwdata[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SPACING:    prdata = APB_DATA_W'(spacing_q);
      REG_CI_SPACING: prdata = APB_DATA_W'(ci_spacing_q);
      REG_BEATS:      prdata = APB_DATA_W'(beats_q);
      REG_NOTE:       prdata = APB_DATA_W'(note_q);
      REG_GROUP_MASK: prdata = APB_DATA_W'(mask_q);
      REG_CI_LENGTH:  prdata = APB_DATA_W'(ci_len_q);
      REG_START_DLY:  prdata = APB_DATA_W'(delay_q);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Clamped counts. A zero beat count means four beats.
  // --------------------------------------------------------------------------
  assign len_c    = (ci_len_q > CI_LEN_W'(MAX_COUNT_IN_BEATS)) ?
                    CI_LEN_W'(MAX_COUNT_IN_BEATS) : ci_len_q;
  assign ci_total = CIS_W'(len_c) * CIS_W'(SUBS_PER_BEAT);

  always_comb begin
    if (beats_q == '0) begin
      beats_c = BEATS_W'(DEFAULT_BEATS);
    end else if (beats_q > BEATS_W'(MAX_BEATS_PER_MEASURE)) begin
      beats_c = BEATS_W'(MAX_BEATS_PER_MEASURE);
    end else begin
      beats_c = beats_q;
    end
  end

  assign subs = SP_W'(beats_c) * SP_W'(SUBS_PER_BEAT);

  // --------------------------------------------------------------------------
  // Shared multiply-and-round unit. Operands are chosen by the state; the
  // rounded product is ready in the following state.
  // --------------------------------------------------------------------------
  always_comb begin
    case (state_q)
      ST_RST_MUL: begin
        mul_a = MUL_A_W'(ci_total);
        mul_b = ci_spacing_q;
      end
      ST_CI_MUL: begin
        mul_a = MUL_A_W'(cis_q);
        mul_b = ci_spacing_q;
      end
      ST_SPAN_MUL: begin
        mul_a = subs;
        mul_b = spacing_q;
      end
      ST_POS_MUL: begin
        mul_a = sp_q;
        mul_b = spacing_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mss_mul_round u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .res_o  (mul_r)
  );

  mss_classify u_cls (
    .sub_i   (sp_sub_q),
    .beat_i  (sp_beat_q),
    .note_i  (note_q),
    .mask_i  (mask_q),
    .click_o (cls)
  );

  // Event positions. A position is due when the sample counter is less than
  // half the counter range past it, which is the sign of the difference.
  assign ci_pos  = SAMPLE_W'(delay_q) + SAMPLE_W'(mul_r);
  assign ci_diff = sample_q - ci_pos;
  assign m_pos   = anchor_q + SAMPLE_W'(mul_r);
  assign m_diff  = sample_q - m_pos;

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign out_load        = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d    = state_q;
    sample_d   = sample_q;
    anchor_d   = anchor_q;
    sp_d       = sp_q;
    sp_sub_d   = sp_sub_q;
    sp_beat_d  = sp_beat_q;
    cis_d      = cis_q;
    cis_sub_d  = cis_sub_q;
    cis_beat_d = cis_beat_q;
    span_d     = span_q;
    kind_d     = kind_q;
    accent_d   = accent_q;
    beat_d     = beat_q;
    counting_d = counting_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_axis_tdata_i[0]) begin
            sample_d   = '0;
            sp_d       = '0;
            sp_sub_d   = '0;
            sp_beat_d  = '0;
            cis_d      = '0;
            cis_sub_d  = '0;
            cis_beat_d = '0;
            state_d    = ST_RST_MUL;
          end else begin
            state_d = ST_CI_MUL;
          end
        end
      end

      ST_RST_MUL: begin
        state_d = ST_RST_ADD;
      end

      ST_RST_ADD: begin
        // The first measure starts after the delay and the whole count-in.
        anchor_d = SAMPLE_W'(delay_q) + SAMPLE_W'(mul_r);
        state_d  = ST_CI_MUL;
      end

      ST_CI_MUL: begin
        state_d = ST_CI_EVAL;
      end

      ST_CI_EVAL: begin
        kind_d     = KIND_NONE;
        accent_d   = ACC_NONE;
        beat_d     = '0;
        counting_d = (cis_beat_q < len_c);
        if ((cis_beat_q < len_c) && !ci_diff[SAMPLE_W-1]) begin
          if ((ci_diff == '0) && (cis_sub_q == '0)) begin
            kind_d = KIND_BEAT;
            beat_d = cis_beat_q;
          end
          cis_d = cis_q + CIS_W'(1);
          if (cis_sub_q == SUB_W'(SUBS_PER_BEAT - 1)) begin
            cis_sub_d  = '0;
            cis_beat_d = cis_beat_q + CI_LEN_W'(1);
          end else begin
            cis_sub_d = cis_sub_q + SUB_W'(1);
          end
        end
        state_d = ST_SPAN_MUL;
      end

      ST_SPAN_MUL: begin
        state_d = ST_SPAN_EVAL;
      end

      ST_SPAN_EVAL: begin
        // A shortened measure closes before its next subtick is looked at.
        span_d = mul_r;
        if (sp_beat_q >= beats_c) begin
          anchor_d  = anchor_q + SAMPLE_W'(mul_r);
          sp_d      = '0;
          sp_sub_d  = '0;
          sp_beat_d = '0;
        end
        state_d = ST_POS_MUL;
      end

      ST_POS_MUL: begin
        state_d = ST_POS_EVAL;
      end

      ST_POS_EVAL: begin
        if (!m_diff[SAMPLE_W-1]) begin
          // A count-in click on the same sample wins over the measure click.
          if ((m_diff == '0) && (kind_q == KIND_NONE)) begin
            kind_d   = cls.kind;
            accent_d = cls.accent;
            beat_d   = (cls.kind != KIND_NONE) ? sp_beat_q[BEAT_NUM_W-1:0] : '0;
          end
          if (sp_sub_q == SUB_W'(SUBS_PER_BEAT - 1)) begin
            if (sp_beat_q + BEATS_W'(1) >= beats_c) begin
              anchor_d  = anchor_q + SAMPLE_W'(span_q);
              sp_d      = '0;
              sp_sub_d  = '0;
              sp_beat_d = '0;
            end else begin
              sp_d      = sp_q + SP_W'(1);
              sp_sub_d  = '0;
              sp_beat_d = sp_beat_q + BEATS_W'(1);
            end
          end else begin
            sp_d     = sp_q + SP_W'(1);
            sp_sub_d = sp_sub_q + SUB_W'(1);
          end
        end
        sample_d = sample_q + SAMPLE_W'(1);
        state_d  = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sample_q   <= '0;
      anchor_q   <= RST_ANCHOR;
      sp_q       <= '0;
      sp_sub_q   <= '0;
      sp_beat_q  <= '0;
      cis_q      <= '0;
      cis_sub_q  <= '0;
      cis_beat_q <= '0;
    end else begin
      state_q    <= state_d;
      sample_q   <= sample_d;
      anchor_q   <= anchor_d;
      sp_q       <= sp_d;
      sp_sub_q   <= sp_sub_d;
      sp_beat_q  <= sp_beat_d;
      cis_q      <= cis_d;
      cis_sub_q  <= cis_sub_d;
      cis_beat_q <= cis_beat_d;
    end
  end

  // Working result fields are rebuilt for every item.
  always_ff @(posedge clk_i) begin
    span_q     <= span_d;
    kind_q     <= kind_d;
    accent_q   <= accent_d;
    beat_q     <= beat_d;
    counting_q <= counting_d;
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q   <= kind_q;
      out_accent_q <= accent_q;
      out_beat_q   <= beat_q;
      out_ci_q     <= counting_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_beat_q, out_accent_q, out_kind_q};
  assign m_axis_tuser_o  = out_ci_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // An accepted item always starts the arithmetic sequence.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_CI_MUL || state_q == ST_RST_MUL))
    else $error("accepted item did not start the sequence");

  // The flat measure subtick always matches its beat and subtick pair.
  a_sp_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_sub_q < SUB_W'(SUBS_PER_BEAT)) &&
    (sp_q == SP_W'(sp_beat_q) * SP_W'(SUBS_PER_BEAT) + SP_W'(sp_sub_q)))
    else $error("measure subtick counters disagree");

  // The flat count-in subtick matches its pair and never runs past the cap.
  a_cis_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cis_sub_q < SUB_W'(SUBS_PER_BEAT)) &&
    (cis_beat_q <= CI_LEN_W'(MAX_COUNT_IN_BEATS)) &&
    (cis_q == CIS_W'(cis_beat_q) * CIS_W'(SUBS_PER_BEAT) + CIS_W'(cis_sub_q)))
    else $error("count-in subtick counters disagree");

  // A new result appears only when the sequencer finishes an item.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_axis_tready_i) || !out_valid_q |=>
      (!out_valid_q || $past(state_q == ST_DONE)))
    else $error("result appeared without a finished item");
`endif

endmodule
